// File: hw/rtl/dq_pkg.sv
// dq_pkg: shared types, constants and pointer helpers for the deque core
// no dependencies

package dq_pkg;

  localparam int DEPTH  = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 64;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] popped;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] front;
    logic [WORD_W-1:0] back;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

// File: hw/rtl/double_ended_queue_core.sv
// double_ended_queue_core: 32-entry deque of 64-bit words on a circular store
// push: result in the cycle after the item is taken, one per cycle unless stalled
// pop: result goes through the store read of the new end word and the output
//   register; no new item is taken while in the read state
// reset clears pointers, count and handshake state; store contents are not cleared

module double_ended_queue_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [dq_pkg::WORD_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [dq_pkg::WORD_W-1:0]  popped_value,
  output logic [dq_pkg::CNT_W-1:0]   count,
  output logic [dq_pkg::WORD_W-1:0]  front_value,
  output logic [dq_pkg::WORD_W-1:0]  back_value
);

  dq_pkg::mem_req_t          mem_req;
  logic [dq_pkg::WORD_W-1:0] rdata;
  dq_pkg::result_t           res;
  logic                      res_load;
  logic                      out_free;

  dq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_stall (in_stall),
    .op       (op),
    .value    (value),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .res_load (res_load),
    .res      (res)
  );

  dq_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res_load),
    .res          (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .free         (out_free),
    .status       (status),
    .popped_value (popped_value),
    .count        (count),
    .front_value  (front_value),
    .back_value   (back_value)
  );

endmodule

// File: hw/rtl/dq_store.sv
// dq_store: entry storage, one write port and one registered read port
// depends on dq_pkg

module dq_store (
  input  logic                       clk,
  input  dq_pkg::mem_req_t           req,
  output logic [dq_pkg::WORD_W-1:0]  rdata
);

  logic [dq_pkg::WORD_W-1:0] mem [dq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: hw/rtl/dq_ctrl.sv
// dq_ctrl: pointers, count, cached end words and the sequencer around the store
// depends on dq_pkg

module dq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_free,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [dq_pkg::WORD_W-1:0]  value,
  output dq_pkg::mem_req_t           mem_req,
  input  logic [dq_pkg::WORD_W-1:0]  rdata,
  output logic                       res_load,
  output dq_pkg::result_t            res
);

  dq_pkg::state_t                  state, state_next;
  logic [dq_pkg::PTR_W-1:0]        head, head_next;
  logic [dq_pkg::PTR_W-1:0]        tail, tail_next;
  logic [dq_pkg::CNT_W-1:0]        entry_count, entry_count_next;
  logic [dq_pkg::WORD_W-1:0]       front_word, front_word_next;
  logic [dq_pkg::WORD_W-1:0]       back_word, back_word_next;
  logic [dq_pkg::WORD_W-1:0]       popped_word, popped_word_next;
  logic                            pend_front, pend_front_next;
  logic                            accept;
  logic                            is_empty;
  logic                            is_full;
  logic [dq_pkg::CNT_W:0]          ptr_sum;
  logic [dq_pkg::PTR_W-1:0]        tail_expect;

  assign is_empty = (entry_count == '0);
  assign is_full  = (entry_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign in_stall = !((state == dq_pkg::S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dq_pkg::S_IDLE;
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      tail        <= tail_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    front_word  <= front_word_next;
    back_word   <= back_word_next;
    popped_word <= popped_word_next;
    pend_front  <= pend_front_next;
  end

  always_comb begin
    logic [dq_pkg::PTR_W-1:0] nptr;
    logic [dq_pkg::CNT_W-1:0] ncnt;
    nptr             = '0;
    ncnt             = '0;
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    entry_count_next = entry_count;
    front_word_next  = front_word;
    back_word_next   = back_word;
    popped_word_next = popped_word;
    pend_front_next  = pend_front;
    mem_req          = '0;
    res_load         = 1'b0;
    res              = '0;
    res.status       = dq_pkg::ST_OK;
    case (state)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          case (dq_pkg::op_t'(op))
            dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
              res_load = 1'b1;
              if (is_full) begin
                res.status = dq_pkg::ST_FULL;
                res.count  = entry_count;
                res.front  = front_word;
                res.back   = back_word;
              end else begin
                ncnt             = entry_count + dq_pkg::CNT_W'(1);
                entry_count_next = ncnt;
                mem_req.we       = 1'b1;
                mem_req.wdata    = value;
                if (dq_pkg::op_t'(op) == dq_pkg::OP_PUSH_BACK) begin
                  mem_req.waddr  = tail;
                  tail_next      = dq_pkg::ptr_inc(tail);
                  back_word_next = value;
                  if (is_empty) begin
                    front_word_next = value;
                  end
                end else begin
                  nptr            = dq_pkg::ptr_dec(head);
                  mem_req.waddr   = nptr;
                  head_next       = nptr;
                  front_word_next = value;
                  if (is_empty) begin
                    back_word_next = value;
                  end
                end
                res.count = ncnt;
                res.front = front_word_next;
                res.back  = back_word_next;
              end
            end
            default: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res.status = dq_pkg::ST_EMPTY;
              end else begin
                entry_count_next = entry_count - dq_pkg::CNT_W'(1);
                mem_req.re       = 1'b1;
                state_next       = dq_pkg::S_READ;
                if (dq_pkg::op_t'(op) == dq_pkg::OP_POP_FRONT) begin
                  popped_word_next = front_word;
                  pend_front_next  = 1'b1;
                  nptr             = dq_pkg::ptr_inc(head);
                  head_next        = nptr;
                  mem_req.raddr    = nptr;
                end else begin
                  popped_word_next = back_word;
                  pend_front_next  = 1'b0;
                  nptr             = dq_pkg::ptr_dec(tail);
                  tail_next        = nptr;
                  mem_req.raddr    = dq_pkg::ptr_dec(nptr);
                end
              end
            end
          endcase
        end
      end
      dq_pkg::S_READ: begin
        state_next = dq_pkg::S_IDLE;
        res_load   = 1'b1;
        res.popped = popped_word;
        res.count  = entry_count;
        if (pend_front) begin
          front_word_next = rdata;
        end else begin
          back_word_next = rdata;
        end
        if (!is_empty) begin
          res.front = front_word_next;
          res.back  = back_word_next;
        end
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  // head plus count, wrapped, must land on tail
  assign ptr_sum     = {1'b0, {(dq_pkg::CNT_W - dq_pkg::PTR_W){1'b0}}, head}
                       + {1'b0, entry_count};
  assign tail_expect = (ptr_sum >= (dq_pkg::CNT_W + 1)'(dq_pkg::DEPTH))
                       ? dq_pkg::PTR_W'(ptr_sum - (dq_pkg::CNT_W + 1)'(dq_pkg::DEPTH))
                       : dq_pkg::PTR_W'(ptr_sum);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
    else $error("entry count above capacity");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    tail == tail_expect)
    else $error("head, tail and count disagree");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == dq_pkg::S_READ |=> state == dq_pkg::S_IDLE)
    else $error("read state held more than one cycle");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    state == dq_pkg::S_READ |-> !mem_req.we && res_load)
    else $error("write or missing result during read state");

  a_read_after_pop: assert property (@(posedge clk) disable iff (rst)
    accept && !is_empty && (op == dq_pkg::OP_POP_BACK || op == dq_pkg::OP_POP_FRONT)
    |=> state == dq_pkg::S_READ && entry_count == $past(entry_count) - dq_pkg::CNT_W'(1))
    else $error("pop did not start a store read");

endmodule

// File: hw/rtl/dq_out.sv
// dq_out: output register holding one result item until taken
// depends on dq_pkg

module dq_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  dq_pkg::result_t            res,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       free,
  output logic [1:0]                 status,
  output logic [dq_pkg::WORD_W-1:0]  popped_value,
  output logic [dq_pkg::CNT_W-1:0]   count,
  output logic [dq_pkg::WORD_W-1:0]  front_value,
  output logic [dq_pkg::WORD_W-1:0]  back_value
);

  dq_pkg::result_t held;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      held <= res;
    end
  end

  assign status       = held.status;
  assign popped_value = held.popped;
  assign count        = held.count;
  assign front_value  = held.front;
  assign back_value   = held.back;

endmodule

// File: tb/tb_double_ended_queue_core.sv
`timescale 1ns / 1ps
// tb_double_ended_queue_core: self-checking bench for the 32-entry deque core
// holds a deque scoreboard class, valid/stall drivers and a cycle watchdog
// depends on dq_pkg and double_ended_queue_core

class deque_scoreboard;
  localparam int unsigned MAX_REPORTS = 10;

  logic [dq_pkg::WORD_W-1:0] slots [dq_pkg::DEPTH];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  int unsigned fill = 0;
  dq_pkg::result_t expected_q[$];
  int unsigned errors = 0;

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void note_item(dq_pkg::op_t o, logic [dq_pkg::WORD_W-1:0] v);
    dq_pkg::result_t r;
    r = '0;
    r.status = dq_pkg::ST_OK;
    case (o)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (fill == dq_pkg::DEPTH) begin
          r.status = dq_pkg::ST_FULL;
        end else if (o == dq_pkg::OP_PUSH_BACK) begin
          slots[tail_idx] = v;
          tail_idx = (tail_idx + 1) % dq_pkg::DEPTH;
          fill++;
        end else begin
          head_idx = (head_idx + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
          slots[head_idx] = v;
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = dq_pkg::ST_EMPTY;
        end else if (o == dq_pkg::OP_POP_BACK) begin
          tail_idx = (tail_idx + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
          r.popped = slots[tail_idx];
          fill--;
        end else begin
          r.popped = slots[head_idx];
          head_idx = (head_idx + 1) % dq_pkg::DEPTH;
          fill--;
        end
      end
    endcase
    r.count = dq_pkg::CNT_W'(fill);
    if (fill != 0) begin
      r.front = slots[head_idx];
      r.back  = slots[(tail_idx + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH];
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(dq_pkg::result_t got);
    dq_pkg::result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected result status %0d count %0d", $realtime, got.status,
                 got.count);
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status || got.popped !== want.popped ||
        got.count !== want.count || got.front !== want.front || got.back !== want.back) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: mismatch, expected status %0d popped %h count %0d front %h back %h",
                 $realtime, want.status, want.popped, want.count, want.front, want.back);
        $display("%0t:           actual status %0d popped %h count %0d front %h back %h",
                 $realtime, got.status, got.popped, got.count, got.front, got.back);
      end
    end
  endfunction
endclass

module tb_double_ended_queue_core;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  op = dq_pkg::OP_PUSH_BACK;
  logic [dq_pkg::WORD_W-1:0]   value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  status;
  logic [dq_pkg::WORD_W-1:0]   popped_value;
  logic [dq_pkg::CNT_W-1:0]    count;
  logic [dq_pkg::WORD_W-1:0]   front_value;
  logic [dq_pkg::WORD_W-1:0]   back_value;

  deque_scoreboard sb;
  int unsigned source_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cycles = 0;
  bit          hold_request = 1'b0;
  bit          hold_taken = 1'b0;

  double_ended_queue_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .popped_value (popped_value),
    .count        (count),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  always #2 clk = ~clk;

  function automatic logic [dq_pkg::WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input dq_pkg::op_t o, input logic [dq_pkg::WORD_W-1:0] v);
    while ($urandom_range(99) < source_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(o, v);
  endtask

  task automatic run_segment(input int unsigned n_items, input int unsigned push_pct);
    repeat (n_items) begin
      if ($urandom_range(99) < push_pct)
        send_item($urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                  rand_word());
      else
        send_item($urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK,
                  rand_word());
    end
  endtask

  // mixes of fill-heavy and drain-heavy stretches so full and empty both recur
  task automatic run_random(input int unsigned n_items);
    int unsigned left;
    int unsigned seg;
    int unsigned push_pct;
    left = n_items;
    while (left != 0) begin
      seg = $urandom_range(90, 30);
      if (seg > left) seg = left;
      case ($urandom_range(4))
        0: push_pct = 100;
        1: push_pct = 85;
        2: push_pct = 50;
        3: push_pct = 15;
        default: push_pct = 0;
      endcase
      run_segment(seg, push_pct);
      left -= seg;
    end
  endtask

  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_cycles <= HOLD_LEN;
      out_stall   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(dq_pkg::result_t'{dq_pkg::status_t'(status), popped_value, count,
                                        front_value, back_value});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** double_ended_queue_core: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    source_idle_pct = 10;
    sink_idle_pct   = 61;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // refused pops on empty, then extremes at both ends and head wrap
    send_item(dq_pkg::OP_POP_BACK, '1);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_PUSH_BACK, '0);
    send_item(dq_pkg::OP_PUSH_BACK, '1);
    send_item(dq_pkg::OP_PUSH_FRONT, 64'h8000_0000_0000_0000);
    send_item(dq_pkg::OP_PUSH_FRONT, 64'h0000_0000_0000_0001);
    send_item(dq_pkg::OP_POP_BACK, '0);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_BACK, '0);
    send_item(dq_pkg::OP_POP_FRONT, '1);
    send_item(dq_pkg::OP_PUSH_FRONT, '1);
    send_item(dq_pkg::OP_POP_BACK, '0);
    send_item(dq_pkg::OP_PUSH_BACK, 64'h5555_5555_5555_5555);
    send_item(dq_pkg::OP_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_FRONT, '0);

    // fill past full, then drain past empty
    run_segment(40, 100);
    run_segment(40, 0);
    run_random(270);

    source_idle_pct = 61;
    sink_idle_pct   = 10;
    run_random(340);

    source_idle_pct = 0;
    sink_idle_pct   = 0;
    hold_request <= 1'b1;
    run_random(340);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("** double_ended_queue_core: PASSED **");
    else
      $display("** double_ended_queue_core: FAILED **");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_store.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_out.sv
hw/rtl/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
